// File: hdl/ble_adv_scan_rsp_sequencer_top_assert.svh
// Assertion macros for the sequencer checker.
`ifndef BLE_ADV_SCAN_RSP_SEQUENCER_TOP_ASSERT_SVH
`define BLE_ADV_SCAN_RSP_SEQUENCER_TOP_ASSERT_SVH

// Implication checked every clock, quiet while reset is asserted.
`define BLESQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("blesq assertion failed");

// Next-cycle implication that also runs during reset.
`define BLESQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("blesq assertion failed");

`endif

// File: hdl/blesq_pkg.sv
// Shared types, codes and tables for the advertising sequencer.
package blesq_pkg;

  localparam int TIMER_BITS = 16;

  localparam int ADDR_W    = 48;
  localparam int CNT_W     = 32;
  localparam int TMO_W     = 16;
  localparam int DLY_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 48;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 112;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RSP_EN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RX_TIMEOUT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RSP_DELAY  = 2'd3;

  // Reset values of the registers
  localparam logic [ADDR_W-1:0] OWN_ADDR_RST   = 48'h665544332211;
  localparam logic [TMO_W-1:0]  RX_TIMEOUT_RST = 16'd500;
  // T_IFS 150 minus TX ramp 40 minus margin 15
  localparam logic [DLY_W-1:0]  RSP_DELAY_RST  = 10'(150 - 40 - 15);

  // Scan request match: PDU type and payload length
  localparam logic [3:0] REQ_PDU_TYPE = 4'd3;
  localparam logic [7:0] REQ_PDU_LEN  = 8'd12;

  localparam logic [5:0] CHAN_FIRST = 6'd37;
  localparam logic [5:0] CHAN_LAST  = 6'd39;
  localparam logic [6:0] FREQ_37 = 7'd2;
  localparam logic [6:0] FREQ_38 = 7'd26;
  localparam logic [6:0] FREQ_39 = 7'd80;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_TX_DONE = 2'd2,
    CMD_RX      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_ADV     = 3'd0,
    ACT_LISTEN  = 3'd1,
    ACT_DISABLE = 3'd2,
    ACT_RSP     = 3'd3,
    ACT_DONE    = 3'd4
  } act_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_TX_ADV = 5'b00010,
    PH_LISTEN = 5'b00100,
    PH_DELAY  = 5'b01000,
    PH_TX_RSP = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [ADDR_W-1:0] own_addr;
    logic              rsp_en;
    logic [TMO_W-1:0]  rx_timeout;
    logic [DLY_W-1:0]  rsp_delay;
  } cfg_t;

  // One result word; last travels as tlast
  typedef struct packed {
    logic             last;
    logic [CNT_W-1:0] evt_total;
    logic [CNT_W-1:0] rsp_total;
    logic [CNT_W-1:0] req_total;
    logic [6:0]       rf_freq;
    logic [5:0]       channel;
    act_t             action;
  } result_t;

  // Channel slot 0..2 maps to RF offset; slot 3 never occurs, treated as 39
  function automatic logic [6:0] slot_freq(input logic [1:0] slot);
    logic [6:0] f;
    case (slot)
      2'd0:    f = FREQ_37;
      2'd1:    f = FREQ_38;
      default: f = FREQ_39;
    endcase
    return f;
  endfunction

  function automatic logic [5:0] slot_chan(input logic [1:0] slot);
    logic [5:0] c;
    case (slot)
      2'd0:    c = CHAN_FIRST;
      2'd1:    c = CHAN_FIRST + 6'd1;
      default: c = CHAN_LAST;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/ble_adv_scan_rsp_sequencer_top.sv
// Top level of the BLE advertising sequencer with scan response.
//
// Input stream: one word per radio event. in_tuser carries the command
// (start, microsecond tick, transmit done, packet received); in_tdata
// carries the received packet fields used with packet received.
// Output stream: radio commands (advertise, listen, disable, scan
// response, event done) with channel, RF offset and the three counters;
// out_tlast marks the last word caused by an input word (one or two).
// Configuration: cfg_we writes cfg_wdata to register cfg_index
// (0 own address, 1 scan response enable, 2 listen timeout,
// 3 response delay); write only while the block is idle.
// An accepted word's results are written into the result queue.
// Throughput: one input word per cycle while each causes at most one
// result and out_tready is high; a two-result word puts two words out.
// The four-entry result queue sets this: in_tready is high while it
// has room for two words, so input keeps flowing while a result waits.
// Reset (rst_n low, synchronous): sequencer idle on channel 37, counters
// cleared, queue emptied, registers back to their defaults, in_tready low.
// A stalled receiver fills the queue, then in_tready drops; nothing is lost.
module ble_adv_scan_rsp_sequencer_top #(
  parameter int TIMER_BITS = blesq_pkg::TIMER_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // rx_type[3:0], rx_length[11:4], rx_adv_address[59:12], rx_crc_ok[60], zero pad
  input  logic [blesq_pkg::IN_DATA_W-1:0]      in_tdata,
  // command[1:0]
  input  logic [1:0]                           in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // action[2:0], channel[8:3], rf_freq[15:9], req_total[47:16],
  // rsp_total[79:48], evt_total[111:80]
  output logic [blesq_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                 out_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [blesq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [blesq_pkg::CFG_DAT_W-1:0]      cfg_wdata
);

  blesq_pkg::cfg_t    cfg;
  blesq_pkg::phase_t  phase_r, phase_nxt;
  logic [1:0]         slot_r, slot_nxt;
  logic [TIMER_BITS-1:0] tmr_r, tmr_nxt;
  logic [blesq_pkg::CNT_W-1:0] req_r, req_nxt;
  logic [blesq_pkg::CNT_W-1:0] rsp_r, rsp_nxt;
  logic [blesq_pkg::CNT_W-1:0] evt_r, evt_nxt;
  logic [1:0]         n_res;
  blesq_pkg::result_t res0, res1, rd;
  logic               room2;
  logic               in_fire;

  assign in_tready = room2 && rst_n;
  assign in_fire   = in_tvalid && in_tready;

  blesq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  blesq_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .cfg       (cfg),
    .cmd       (blesq_pkg::cmd_t'(in_tuser)),
    .rx_type   (in_tdata[3:0]),
    .rx_length (in_tdata[11:4]),
    .rx_addr   (in_tdata[59:12]),
    .rx_crc_ok (in_tdata[60]),
    .phase     (phase_r),
    .slot      (slot_r),
    .tmr       (tmr_r),
    .req_cnt   (req_r),
    .rsp_cnt   (rsp_r),
    .evt_cnt   (evt_r),
    .phase_nxt (phase_nxt),
    .slot_nxt  (slot_nxt),
    .tmr_nxt   (tmr_nxt),
    .req_nxt   (req_nxt),
    .rsp_nxt   (rsp_nxt),
    .evt_nxt   (evt_nxt),
    .n_res     (n_res),
    .res0      (res0),
    .res1      (res1)
  );

  // Sequencer state advances on every accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= blesq_pkg::PH_IDLE;
      slot_r  <= '0;
      tmr_r   <= '0;
      req_r   <= '0;
      rsp_r   <= '0;
      evt_r   <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      slot_r  <= slot_nxt;
      tmr_r   <= tmr_nxt;
      req_r   <= req_nxt;
      rsp_r   <= rsp_nxt;
      evt_r   <= evt_nxt;
    end
  end

  blesq_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (in_fire ? n_res : 2'd0),
    .wr0       (res0),
    .wr1       (res1),
    .room2     (room2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .rd        (rd)
  );

  assign out_tdata = {rd.evt_total, rd.rsp_total, rd.req_total,
                      rd.rf_freq, rd.channel, rd.action};
  assign out_tlast = rd.last;

endmodule

// File: hdl/blesq_cfg.sv
// Configuration register bank.
module blesq_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [blesq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blesq_pkg::CFG_DAT_W-1:0]   cfg_wdata,
  output blesq_pkg::cfg_t                   cfg
);

  blesq_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_addr   <= blesq_pkg::OWN_ADDR_RST;
      cfg_r.rsp_en     <= 1'b1;
      cfg_r.rx_timeout <= blesq_pkg::RX_TIMEOUT_RST;
      cfg_r.rsp_delay  <= blesq_pkg::RSP_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        blesq_pkg::REG_OWN_ADDR:   cfg_r.own_addr   <= cfg_wdata[blesq_pkg::ADDR_W-1:0];
        blesq_pkg::REG_RSP_EN:     cfg_r.rsp_en     <= cfg_wdata[0];
        blesq_pkg::REG_RX_TIMEOUT: cfg_r.rx_timeout <= cfg_wdata[blesq_pkg::TMO_W-1:0];
        blesq_pkg::REG_RSP_DELAY:  cfg_r.rsp_delay  <= cfg_wdata[blesq_pkg::DLY_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/blesq_step.sv
// Next-state and result logic for one input word.
module blesq_step #(
  parameter int TIMER_BITS = blesq_pkg::TIMER_BITS
) (
  input  blesq_pkg::cfg_t                   cfg,
  input  blesq_pkg::cmd_t                   cmd,
  input  logic [3:0]                        rx_type,
  input  logic [7:0]                        rx_length,
  input  logic [blesq_pkg::ADDR_W-1:0]      rx_addr,
  input  logic                              rx_crc_ok,
  input  blesq_pkg::phase_t                 phase,
  input  logic [1:0]                        slot,
  input  logic [TIMER_BITS-1:0]             tmr,
  input  logic [blesq_pkg::CNT_W-1:0]       req_cnt,
  input  logic [blesq_pkg::CNT_W-1:0]       rsp_cnt,
  input  logic [blesq_pkg::CNT_W-1:0]       evt_cnt,
  output blesq_pkg::phase_t                 phase_nxt,
  output logic [1:0]                        slot_nxt,
  output logic [TIMER_BITS-1:0]             tmr_nxt,
  output logic [blesq_pkg::CNT_W-1:0]       req_nxt,
  output logic [blesq_pkg::CNT_W-1:0]       rsp_nxt,
  output logic [blesq_pkg::CNT_W-1:0]       evt_nxt,
  output logic [1:0]                        n_res,
  output blesq_pkg::result_t                res0,
  output blesq_pkg::result_t                res1
);

  localparam int CMP_W = (TIMER_BITS > blesq_pkg::TMO_W) ? TIMER_BITS : blesq_pkg::TMO_W;
  localparam logic [TIMER_BITS-1:0] TMR_TOP = {TIMER_BITS{1'b1}};

  logic [TIMER_BITS-1:0] tmr_inc;
  logic                  tmr_at_top;
  logic                  fire_tmo;
  logic                  fire_dly;
  logic                  req_match;
  logic                  adv_last;
  logic [1:0]            adv_slot;
  blesq_pkg::act_t       adv_act;
  blesq_pkg::act_t       act0;
  blesq_pkg::act_t       act1;
  logic [1:0]            rslot0;
  logic [1:0]            rslot1;

  // Saturating tick count and the two wait compares
  assign tmr_at_top = (tmr == TMR_TOP);
  assign tmr_inc    = tmr_at_top ? tmr : tmr + TIMER_BITS'(1);
  assign fire_tmo   = (CMP_W'(tmr_inc) >= CMP_W'(cfg.rx_timeout)) || (tmr_inc == TMR_TOP);
  assign fire_dly   = (CMP_W'(tmr_inc) >= CMP_W'(cfg.rsp_delay)) || (tmr_inc == TMR_TOP);

  assign req_match = rx_crc_ok && (rx_type == blesq_pkg::REQ_PDU_TYPE) &&
                     (rx_length == blesq_pkg::REQ_PDU_LEN) && (rx_addr == cfg.own_addr);

  // Move on: next channel, or close the event after the third one
  assign adv_last = (slot >= 2'd2);
  assign adv_slot = adv_last ? 2'd2 : slot + 2'd1;
  assign adv_act  = adv_last ? blesq_pkg::ACT_DONE : blesq_pkg::ACT_ADV;

  always_comb begin
    phase_nxt = phase;
    slot_nxt  = slot;
    tmr_nxt   = tmr;
    req_nxt   = req_cnt;
    rsp_nxt   = rsp_cnt;
    evt_nxt   = evt_cnt;
    n_res     = 2'd0;
    act0      = blesq_pkg::ACT_ADV;
    act1      = blesq_pkg::ACT_ADV;
    rslot0    = slot;
    rslot1    = slot;
    case (phase)
      blesq_pkg::PH_IDLE: begin
        if (cmd == blesq_pkg::CMD_START) begin
          slot_nxt  = 2'd0;
          phase_nxt = blesq_pkg::PH_TX_ADV;
          n_res     = 2'd1;
          act0      = blesq_pkg::ACT_ADV;
          rslot0    = 2'd0;
        end
      end
      blesq_pkg::PH_TX_ADV: begin
        if (cmd == blesq_pkg::CMD_TX_DONE) begin
          n_res = 2'd1;
          if (cfg.rsp_en) begin
            tmr_nxt   = '0;
            phase_nxt = blesq_pkg::PH_LISTEN;
            act0      = blesq_pkg::ACT_LISTEN;
          end else begin
            slot_nxt  = adv_last ? 2'd0 : adv_slot;
            phase_nxt = adv_last ? blesq_pkg::PH_IDLE : blesq_pkg::PH_TX_ADV;
            evt_nxt   = adv_last ? evt_cnt + 32'd1 : evt_cnt;
            act0      = adv_act;
            rslot0    = adv_slot;
          end
        end
      end
      blesq_pkg::PH_LISTEN: begin
        if (cmd == blesq_pkg::CMD_TICK) begin
          tmr_nxt = tmr_inc;
          if (fire_tmo) begin
            // disable on this channel, then move on
            n_res     = 2'd2;
            act0      = blesq_pkg::ACT_DISABLE;
            act1      = adv_act;
            rslot1    = adv_slot;
            slot_nxt  = adv_last ? 2'd0 : adv_slot;
            phase_nxt = adv_last ? blesq_pkg::PH_IDLE : blesq_pkg::PH_TX_ADV;
            evt_nxt   = adv_last ? evt_cnt + 32'd1 : evt_cnt;
          end
        end else if (cmd == blesq_pkg::CMD_RX) begin
          if (req_match) begin
            req_nxt = req_cnt + 32'd1;
            tmr_nxt = '0;
            if (cfg.rsp_delay == '0) begin
              phase_nxt = blesq_pkg::PH_TX_RSP;
              n_res     = 2'd1;
              act0      = blesq_pkg::ACT_RSP;
            end else begin
              phase_nxt = blesq_pkg::PH_DELAY;
            end
          end else begin
            n_res     = 2'd1;
            act0      = adv_act;
            rslot0    = adv_slot;
            slot_nxt  = adv_last ? 2'd0 : adv_slot;
            phase_nxt = adv_last ? blesq_pkg::PH_IDLE : blesq_pkg::PH_TX_ADV;
            evt_nxt   = adv_last ? evt_cnt + 32'd1 : evt_cnt;
          end
        end
      end
      blesq_pkg::PH_DELAY: begin
        if (cmd == blesq_pkg::CMD_TICK) begin
          tmr_nxt = tmr_inc;
          if (fire_dly) begin
            phase_nxt = blesq_pkg::PH_TX_RSP;
            n_res     = 2'd1;
            act0      = blesq_pkg::ACT_RSP;
          end
        end
      end
      blesq_pkg::PH_TX_RSP: begin
        if (cmd == blesq_pkg::CMD_TX_DONE) begin
          rsp_nxt   = rsp_cnt + 32'd1;
          n_res     = 2'd1;
          act0      = adv_act;
          rslot0    = adv_slot;
          slot_nxt  = adv_last ? 2'd0 : adv_slot;
          phase_nxt = adv_last ? blesq_pkg::PH_IDLE : blesq_pkg::PH_TX_ADV;
          evt_nxt   = adv_last ? evt_cnt + 32'd1 : evt_cnt;
        end
      end
      default: phase_nxt = blesq_pkg::PH_IDLE;
    endcase
  end

  // Both words carry the counters as they stand after this input
  always_comb begin
    res0.action    = act0;
    res0.channel   = blesq_pkg::slot_chan(rslot0);
    res0.rf_freq   = blesq_pkg::slot_freq(rslot0);
    res0.req_total = req_nxt;
    res0.rsp_total = rsp_nxt;
    res0.evt_total = evt_nxt;
    res0.last      = (n_res == 2'd1);
    res1.action    = act1;
    res1.channel   = blesq_pkg::slot_chan(rslot1);
    res1.rf_freq   = blesq_pkg::slot_freq(rslot1);
    res1.req_total = req_nxt;
    res1.rsp_total = rsp_nxt;
    res1.evt_total = evt_nxt;
    res1.last      = 1'b1;
  end

endmodule

// File: hdl/blesq_outq.sv
// Four-entry result queue: up to two words in, one word out per cycle while out_ready is high.
module blesq_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         push_cnt,
  input  blesq_pkg::result_t wr0,
  input  blesq_pkg::result_t wr1,
  output logic               room2,
  output logic               out_valid,
  input  logic               out_ready,
  output blesq_pkg::result_t rd
);

  blesq_pkg::result_t mem [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != 3'd0);
  assign room2     = (count_r <= 3'd2);
  assign rd        = mem[rd_ptr_r];

  assign wr_ptr_nxt = wr_ptr_r + push_cnt;
  assign rd_ptr_nxt = rd_ptr_r + 2'(pop);
  assign count_nxt  = count_r + 3'(push_cnt) - 3'(pop);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= wr0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_r + 2'd1] <= wr1;
    end
  end

endmodule

// File: hdl/blesq_checker.sv
// Port-level checks for the sequencer, bound to the top level.
`include "ble_adv_scan_rsp_sequencer_top_assert.svh"

module blesq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic [blesq_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                              out_tlast,
  input logic                              out_tvalid,
  input logic                              out_tready
);

  logic out_fire;
  logic is_done;
  logic on_last_chan;
  logic chan_ok;

  assign out_fire     = out_tvalid && out_tready;
  assign is_done      = (out_tdata[2:0] == blesq_pkg::ACT_DONE);
  assign on_last_chan = (out_tdata[8:3] == blesq_pkg::CHAN_LAST);

  // channel and RF offset pairs that may appear
  assign chan_ok = (out_tdata[8:3] == blesq_pkg::CHAN_FIRST &&
                    out_tdata[15:9] == blesq_pkg::FREQ_37) ||
                   (out_tdata[8:3] == blesq_pkg::CHAN_FIRST + 6'd1 &&
                    out_tdata[15:9] == blesq_pkg::FREQ_38) ||
                   (on_last_chan && out_tdata[15:9] == blesq_pkg::FREQ_39);

  // queue is empty right after reset
  `BLESQ_ASSERT_NXT(a_rst_empty, !rst_n, !out_tvalid)
  // a waiting word stays offered
  `BLESQ_ASSERT_IMP(a_out_hold, out_tvalid && !out_tready, ##1 out_tvalid)
  // RF offset always follows the channel
  `BLESQ_ASSERT_IMP(a_chan_freq, out_tvalid, chan_ok)
  // event done closes a run on the last channel
  `BLESQ_ASSERT_IMP(a_done_last, out_fire && is_done, out_tlast && on_last_chan)

endmodule

bind ble_adv_scan_rsp_sequencer_top blesq_checker u_blesq_checker (.*);
